/* hdl/e2q_pkg.sv */
// Package for the Euler-angle to quaternion converter: CORDIC constants,
// arctangent table and the per-angle CORDIC lane type. No dependencies.
package e2q_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int CW           = 34;   // CORDIC x/y datapath width (Q2.30 + guard)
    localparam int ZW           = 32;   // residual phase width
    localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30   = 34'sd1073741824;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [1:0]           quad;
    } t_lane;

    function automatic logic signed [ZW-1:0] atan_val(input int i);
        logic signed [ZW-1:0] r;
        begin
            unique case (i)
                0:  r = 32'sh20000000;
                1:  r = 32'sh12E4051E;
                2:  r = 32'sh09FB385B;
                3:  r = 32'sh051111D4;
                4:  r = 32'sh028B0D43;
                5:  r = 32'sh0145D7E1;
                6:  r = 32'sh00A2F61E;
                7:  r = 32'sh00517C55;
                8:  r = 32'sh0028BE53;
                9:  r = 32'sh00145F2F;
                10: r = 32'sh000A2F98;
                11: r = 32'sh000517CC;
                12: r = 32'sh00028BE6;
                13: r = 32'sh000145F3;
                14: r = 32'sh0000A2F9;
                15: r = 32'sh0000517C;
                16: r = 32'sh000028BE;
                17: r = 32'sh0000145F;
                18: r = 32'sh00000A2F;
                19: r = 32'sh00000517;
                20: r = 32'sh0000028B;
                21: r = 32'sh00000145;
                22: r = 32'sh000000A2;
                default: r = 32'sh00000051;
            endcase
            return r;
        end
    endfunction

endpackage

/* hdl/e2q_if.sv */
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface e2q_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/e2q_cell.sv */
// One CORDIC micro-rotation cell for the three angle lanes.
// Depends on e2q_pkg.
module e2q_cell
    import e2q_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic     i_clk,
    input  logic     i_en,
    input  t_lane    i_lane [3],
    output t_lane    o_lane [3]
);
    t_lane n_lane [3];
    t_lane r_lane [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_lane[k].quad = i_lane[k].quad;
            if (!i_lane[k].z[ZW-1]) begin
                n_lane[k].x = i_lane[k].x - (i_lane[k].y >>> STEP);
                n_lane[k].y = i_lane[k].y + (i_lane[k].x >>> STEP);
                n_lane[k].z = i_lane[k].z - atan_val(STEP);
            end else begin
                n_lane[k].x = i_lane[k].x + (i_lane[k].y >>> STEP);
                n_lane[k].y = i_lane[k].y - (i_lane[k].x >>> STEP);
                n_lane[k].z = i_lane[k].z + atan_val(STEP);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;
endmodule

/* hdl/euler_to_quaternion.sv */
// Top level: Z-Y-X Euler angles to unit quaternion, CORDIC cell chain
// plus product pipeline. Depends on e2q_pkg, e2q_if, e2q_cell.
//
//  channel  | dir | payload
//  s_in     | in  | roll, pitch, yaw angles (ANGLE_WIDTH each)
//  m_out    | out | quat w, x, y, z (QUAT_FRAC_BITS+2 each)
//
// One request per cycle unless the output stalls; 1 + 24 CORDIC cells + 5
// product stages. The whole pipe advances together; a stall on the output
// (valid and not ready) freezes every stage. Reset clears the valid bits.
module euler_to_quaternion
    import e2q_pkg::*;
#(
    parameter int ANGLE_WIDTH    = 18,
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    e2q_if.sink   s_in,
    e2q_if.source m_out
);
    localparam int OW    = QUAT_FRAC_BITS + 2;
    localparam int DEPTH = 1 + CORDIC_STEPS + 5;
    localparam int SH    = 60 - QUAT_FRAC_BITS;

    logic             en;
    logic [DEPTH-1:0] r_vld;

    assign en         = !m_out.valid || m_out.ready;
    assign s_in.ready = en;
    assign m_out.valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], s_in.valid};
        end
    end

    // Stage 0: quadrant split
    t_lane n_init [3];
    t_lane r_init [3];
    always_comb begin
        logic [31:0] ph;
        logic [1:0]  q;
        for (int k = 0; k < 3; k++) begin
            ph = {s_in.data[k*ANGLE_WIDTH +: ANGLE_WIDTH], {(32-ANGLE_WIDTH){1'b0}}};
            q  = 2'((ph + 32'h2000_0000) >> 30);
            n_init[k].quad = q;
            n_init[k].z    = $signed(ph - {q, 30'd0});
            n_init[k].x    = CORDIC_X0;
            n_init[k].y    = '0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_init <= n_init;
        end
    end

    t_lane chain [CORDIC_STEPS+1][3];
    assign chain[0] = r_init;
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        e2q_cell #(.STEP(g)) u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_lane (chain[g]),
            .o_lane (chain[g+1])
        );
    end

    // Quadrant rotate and clamp: index 0 roll, 1 pitch, 2 yaw
    function automatic logic signed [CW-1:0] clampq(input logic signed [CW-1:0] v);
        if (v > ONE_Q30) return ONE_Q30;
        if (v < -ONE_Q30) return -ONE_Q30;
        return v;
    endfunction

    logic signed [CW-1:0] n_c [3], n_s [3];
    logic signed [CW-1:0] r_c [3], r_s [3];
    always_comb begin
        t_lane l;
        for (int k = 0; k < 3; k++) begin
            l = chain[CORDIC_STEPS][k];
            unique case (l.quad)
                2'd0: begin n_c[k] = l.x;  n_s[k] = l.y;  end
                2'd1: begin n_c[k] = -l.y; n_s[k] = l.x;  end
                2'd2: begin n_c[k] = -l.x; n_s[k] = -l.y; end
                default: begin n_c[k] = l.y; n_s[k] = -l.x; end
            endcase
            n_c[k] = clampq(n_c[k]);
            n_s[k] = clampq(n_s[k]);
        end
    end

    // Pair products (yaw x pitch), rounded to Q30
    logic signed [CW-1:0] r_cc, r_sc, r_cs, r_ss, r_cr2, r_sr2;
    function automatic logic signed [CW-1:0] mq(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
        logic signed [2*CW-1:0] p;
        p = a * b + (68'sd1 <<< 29);
        return CW'(p >>> 30);
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_c[k] <= n_c[k];
                r_s[k] <= n_s[k];
            end
            r_cc  <= mq(r_c[2], r_c[1]);
            r_sc  <= mq(r_s[2], r_c[1]);
            r_cs  <= mq(r_c[2], r_s[1]);
            r_ss  <= mq(r_s[2], r_s[1]);
            r_cr2 <= r_c[0];
            r_sr2 <= r_s[0];
        end
    end

    // Eight Q60 products, then sums, then rounding
    logic signed [63:0] r_p [8];
    logic signed [64:0] r_sum [4];
    logic [OW-1:0]      r_q [4];

    function automatic logic [OW-1:0] to_out(input logic signed [64:0] v);
        logic signed [64:0] r;
        logic signed [64:0] lim;
        r   = (v + (65'sd1 <<< (SH-1))) >>> SH;
        lim = 65'sd1 <<< QUAT_FRAC_BITS;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return OW'(r);
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p[0] <= 64'(r_cc) * 64'(r_cr2);
            r_p[1] <= 64'(r_ss) * 64'(r_sr2);
            r_p[2] <= 64'(r_cc) * 64'(r_sr2);
            r_p[3] <= 64'(r_ss) * 64'(r_cr2);
            r_p[4] <= 64'(r_sc) * 64'(r_sr2);
            r_p[5] <= 64'(r_cs) * 64'(r_cr2);
            r_p[6] <= 64'(r_sc) * 64'(r_cr2);
            r_p[7] <= 64'(r_cs) * 64'(r_sr2);
            r_sum[0] <= 65'(r_p[0]) + 65'(r_p[1]);
            r_sum[1] <= 65'(r_p[2]) - 65'(r_p[3]);
            r_sum[2] <= 65'(r_p[4]) + 65'(r_p[5]);
            r_sum[3] <= 65'(r_p[6]) - 65'(r_p[7]);
            for (int k = 0; k < 4; k++) begin
                r_q[k] <= to_out(r_sum[k]);
            end
        end
    end

    assign m_out.data = {r_q[3], r_q[2], r_q[1], r_q[0]};

    // w output never exceeds +1 (to_out clamps every part to +-1)
    a_sat_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid |-> ($signed(r_q[0]) <= (1 <<< QUAT_FRAC_BITS)))
        else $error("quat_w above one");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && !m_out.ready) |=> (m_out.valid && $stable(r_vld)))
        else $error("pipe moved during stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_out.valid |-> s_in.ready)
        else $error("not ready while output empty");
endmodule

/* tb/euler_to_quaternion_test.sv */
// Testbench for euler_to_quaternion: drives roll/pitch/yaw requests over e2q_if,
// predicts each quaternion with a local CORDIC and product model, checks in order.
// Depends on e2q_pkg, e2q_if and the euler_to_quaternion RTL.
`timescale 1ns / 1ps

module euler_to_quaternion_test;
    import e2q_pkg::*;

    localparam int AW = 18;
    localparam int FB = 14;
    localparam int OW = FB + 2;
    localparam int LATENCY = 30;
    localparam longint GAIN_X0 = 64'sd652032874;
    localparam longint UNIT_Q30 = 64'sd1073741824;

    // w sits in the low bits of the payload
    typedef struct packed {
        logic signed [OW-1:0] z;
        logic signed [OW-1:0] y;
        logic signed [OW-1:0] x;
        logic signed [OW-1:0] w;
    } t_quat;

    localparam longint ATAN_Q32 [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C,
        64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    e2q_if #(.W(3*AW)) angle_ch ();
    e2q_if #(.W(4*OW)) quat_ch ();

    euler_to_quaternion u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (angle_ch.sink),
        .m_out   (quat_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_quat  quat_due [$];
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_off_req = 0;
    int     n_requests = 0;
    int     n_checked = 0;
    int     n_errors = 0;

    // half-angle cos/sin in Q30 for one angle code
    function automatic void half_trig(input logic [AW-1:0] code,
                                      output longint c, output longint s);
        logic [31:0] phase;
        logic [31:0] resid;
        logic [1:0]  quad;
        longint x, y, z, xs, ys;
        phase = {code, {(32-AW){1'b0}}};
        quad  = 2'((phase + 32'h20000000) >> 30);
        resid = phase - ({30'd0, quad} << 30);
        z = longint'($signed(resid));
        x = GAIN_X0;
        y = 0;
        for (int i = 0; i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - ATAN_Q32[i];
            end else begin
                x = x + ys; y = y - xs; z = z + ATAN_Q32[i];
            end
        end
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        if (c > UNIT_Q30) c = UNIT_Q30;
        if (c < -UNIT_Q30) c = -UNIT_Q30;
        if (s > UNIT_Q30) s = UNIT_Q30;
        if (s < -UNIT_Q30) s = -UNIT_Q30;
    endfunction

    function automatic longint round_q30(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic logic [OW-1:0] round_part(input longint v);
        longint r;
        r = (v + (64'sd1 <<< (59 - FB))) >>> (60 - FB);
        if (r > (64'sd1 <<< FB)) r = 64'sd1 <<< FB;
        if (r < -(64'sd1 <<< FB)) r = -(64'sd1 <<< FB);
        return r[OW-1:0];
    endfunction

    function automatic t_quat zyx_quat(input logic [AW-1:0] roll,
                                       input logic [AW-1:0] pitch,
                                       input logic [AW-1:0] yaw);
        longint cr, sr, cp, sp, cy, sy, cc, sc, cs, ss;
        t_quat q;
        half_trig(roll, cr, sr);
        half_trig(pitch, cp, sp);
        half_trig(yaw, cy, sy);
        cc = round_q30(cy, cp);
        sc = round_q30(sy, cp);
        cs = round_q30(cy, sp);
        ss = round_q30(sy, sp);
        q.w = round_part(cc * cr + ss * sr);
        q.x = round_part(cc * sr - ss * cr);
        q.y = round_part(sc * sr + cs * cr);
        q.z = round_part(sc * cr - cs * sr);
        return q;
    endfunction

    // one request; valid stays high across back-to-back sends
    task automatic send_attitude(input logic [AW-1:0] roll, input logic [AW-1:0] pitch,
                                 input logic [AW-1:0] yaw);
        t_quat q;
        q = zyx_quat(roll, pitch, yaw);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            angle_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        angle_ch.valid <= 1'b1;
        // roll in the low bits
        angle_ch.data  <= {yaw, pitch, roll};
        do @(posedge i_clk); while (!angle_ch.ready);
        quat_due.push_back(q);
        n_requests++;
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++)
            send_attitude(AW'($urandom), AW'($urandom), AW'($urandom));
    endtask

    task automatic wait_drained;
        angle_ch.valid <= 1'b0;
        while (quat_due.size() != 0) @(posedge i_clk);
    endtask

    // receiver back-pressure, with a counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_off_req > 0) begin
            quat_ch.ready <= 1'b0;
            hold_off_req <= hold_off_req - 1;
        end else begin
            quat_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_quat got, want;
        if (i_rst_n && quat_ch.valid && quat_ch.ready) begin
            got = quat_ch.data;
            if (quat_due.size() == 0) begin
                $display("%0t: unexpected quaternion %h", $time, got);
                n_errors++;
            end else begin
                want = quat_due.pop_front();
                n_checked++;
                if (got.w !== want.w)
                    $display("%0t: w expected %0d got %0d", $time, want.w, got.w);
                if (got.x !== want.x)
                    $display("%0t: x expected %0d got %0d", $time, want.x, got.x);
                if (got.y !== want.y)
                    $display("%0t: y expected %0d got %0d", $time, want.y, got.y);
                if (got.z !== want.z)
                    $display("%0t: z expected %0d got %0d", $time, want.z, got.z);
                if (got !== want) n_errors++;
            end
        end
    end

    task automatic test_directed;
        logic [AW-1:0] codes [10];
        codes = '{18'h00000, 18'h1FFFF, 18'h20000, 18'h00001, 18'h3FFFF,
                  18'h10000, 18'h30000, 18'h08000, 18'h38000, 18'h2AAAA};
        foreach (codes[i]) send_attitude(codes[i], codes[(i+3)%10], codes[(i+7)%10]);
        // single-axis rotations and gimbal-lock pitch
        send_attitude(18'h10000, 18'h0, 18'h0);
        send_attitude(18'h0, 18'h10000, 18'h0);
        send_attitude(18'h0, 18'h0, 18'h10000);
        send_attitude(18'h08000, 18'h08000, 18'h08000);
        send_attitude(18'h20000, 18'h20000, 18'h20000);
        send_attitude(18'h1FFFF, 18'h1FFFF, 18'h1FFFF);
        send_attitude(18'h3FFFF, 18'h20000, 18'h00001);
        send_attitude(18'h04000, 18'h3C000, 18'h0C000);
        wait_drained();
    endtask

    task automatic test_random_flow(input int idle, input int stall, input int n);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        send_random(n);
    endtask

    task automatic test_hold_off;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_req   = 200;
        send_random(80);
        // sender pauses until everything is back
        wait_drained();
        send_random(20);
        wait_drained();
    endtask

    initial begin
        angle_ch.valid = 1'b0;
        angle_ch.data  = '0;
        quat_ch.ready  = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_flow(0, 0, 300);
        test_random_flow(74, 0, 200);
        test_random_flow(0, 74, 200);
        test_random_flow(13, 13, 200);
        test_random_flow(0, 0, 100);
        test_hold_off();
        recv_stall_pct = 0;
        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Ran %0d attitude requests (directed corners, random angles, idle mixes,",
                 n_requests);
        $display("long output hold-off), %0d quaternions checked.", n_checked);
        if (n_errors == 0 && quat_due.size() == 0) begin
            $display("PASS euler_to_quaternion");
        end else begin
            $display("FAIL euler_to_quaternion");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timed out with %0d quaternions outstanding", quat_due.size());
        $display("FAIL euler_to_quaternion");
        $finish;
    end

endmodule
